// ===== hdl/sco_pkg.sv =====
package sco_pkg;

  localparam int MAX_ASSETS_DEF  = 8;
  localparam int MAX_PERIODS_DEF = 256;
  localparam int SAMPLE_BITS     = 16;
  localparam int ACC_BITS        = 42;
  localparam int ASSET_BITS      = 3;
  localparam int PERIOD_BITS     = 8;
  localparam int NA_BITS         = 4;
  localparam int NP_BITS         = 9;
  localparam int CFG_BITS        = 9;
  localparam int DEV_BITS        = SAMPLE_BITS + 1;
  localparam int PROD_BITS       = 2 * DEV_BITS;

  localparam logic CFG_NUM_ASSETS  = 1'b0;
  localparam logic CFG_NUM_PERIODS = 1'b1;

  typedef struct packed {
    logic                  issue;
    logic                  cov_mode;
    logic [ASSET_BITS-1:0] row;
    logic [ASSET_BITS-1:0] col;
    logic                  div_start;
    logic [NP_BITS-1:0]    divisor;
    logic                  mean_we;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic div_done;
  } status_t;

endpackage

// ===== hdl/sco_div.sv =====
module sco_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [sco_pkg::ACC_BITS-1:0] dividend_i,
  input  logic [sco_pkg::NP_BITS-1:0]         divisor_i,
  output logic                                done_o,
  output logic signed [sco_pkg::ACC_BITS-1:0] quotient_o
);

  localparam int AB = sco_pkg::ACC_BITS;
  localparam int NB = sco_pkg::NP_BITS;
  localparam int CB = $clog2(AB);

  logic          busy_q, done_q, neg_q;
  logic [CB-1:0] cnt_q;
  logic [AB-1:0] dq_q, quo_q, dq_d;
  logic [NB-1:0] rem_q, dvs_q, rem_d;
  logic [NB:0]   shifted;
  logic          bit_d;

  // one quotient bit per cycle, restoring
  always_comb begin
    shifted = {rem_q, dq_q[AB-1]};
    bit_d   = (shifted >= {1'b0, dvs_q});
    rem_d   = bit_d ? NB'(shifted - {1'b0, dvs_q}) : NB'(shifted);
    dq_d    = {dq_q[AB-2:0], bit_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CB'(AB - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[AB-1];
      dq_q  <= dividend_i[AB-1] ? AB'(-dividend_i) : AB'(dividend_i);
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      dq_q  <= dq_d;
      rem_q <= rem_d;
      if (cnt_q == CB'(AB - 1)) begin
        quo_q <= neg_q ? AB'(-dq_d) : dq_d;
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== hdl/sco_datapath.sv =====
module sco_datapath #(
  parameter int MAX_ASSETS  = sco_pkg::MAX_ASSETS_DEF,
  parameter int MAX_PERIODS = sco_pkg::MAX_PERIODS_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_we_i,
  input  logic [sco_pkg::ASSET_BITS-1:0]          asset_index_i,
  input  logic [sco_pkg::PERIOD_BITS-1:0]         period_index_i,
  input  logic signed [sco_pkg::SAMPLE_BITS-1:0]  sample_value_i,
  input  sco_pkg::cmd_t                           cmd_i,
  input  logic [$clog2(MAX_PERIODS)-1:0]          period_i,
  output sco_pkg::status_t                        status_o,
  output logic signed [sco_pkg::ACC_BITS-1:0]     result_o
);

  localparam int DEPTH = MAX_ASSETS * MAX_PERIODS;
  localparam int AW    = $clog2(DEPTH);
  localparam int MIW   = (MAX_ASSETS > 1) ? $clog2(MAX_ASSETS) : 1;
  localparam int SB    = sco_pkg::SAMPLE_BITS;
  localparam int DB    = sco_pkg::DEV_BITS;
  localparam int PB    = sco_pkg::PROD_BITS;
  localparam int AB    = sco_pkg::ACC_BITS;

  logic signed [SB-1:0] mem [DEPTH];
  logic signed [SB-1:0] mean_mem [MAX_ASSETS];

  logic [AW-1:0]        wr_addr, addr_a, addr_b;
  logic                 wr_ok;
  logic signed [SB-1:0] sa_q, sb_q, ma_q, mb_q;
  logic                 v1_q, v2_q, mode1_q;
  logic signed [DB-1:0] da, db;
  logic signed [AB-1:0] add_q, acc_q;
  logic                 div_done;

  assign wr_ok   = (32'(asset_index_i) < MAX_ASSETS) && (32'(period_index_i) < MAX_PERIODS);
  assign wr_addr = AW'(32'(asset_index_i) * MAX_PERIODS + 32'(period_index_i));
  assign addr_a  = AW'(32'(cmd_i.row) * MAX_PERIODS + 32'(period_i));
  assign addr_b  = AW'(32'(cmd_i.col) * MAX_PERIODS + 32'(period_i));

  always_ff @(posedge clk_i) begin
    if (in_we_i && wr_ok) begin
      mem[wr_addr] <= sample_value_i;
    end
    if (cmd_i.issue) begin
      sa_q <= mem[addr_a];
      sb_q <= mem[addr_b];
      ma_q <= mean_mem[cmd_i.row[MIW-1:0]];
      mb_q <= mean_mem[cmd_i.col[MIW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mean_we) begin
      mean_mem[cmd_i.row[MIW-1:0]] <= result_o[SB-1:0];
    end
  end

  assign da = DB'(sa_q) - DB'(ma_q);
  assign db = DB'(sb_q) - DB'(mb_q);

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      if (mode1_q) begin
        add_q <= AB'(PB'(da * db));
      end else begin
        add_q <= AB'(sa_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      mode1_q <= 1'b0;
      acc_q   <= '0;
    end else begin
      v1_q    <= cmd_i.issue;
      mode1_q <= cmd_i.cov_mode;
      v2_q    <= v1_q;
      if (cmd_i.div_start) begin
        acc_q <= '0;
      end else if (v2_q) begin
        acc_q <= acc_q + add_q;
      end
    end
  end

  sco_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (acc_q),
    .divisor_i  (cmd_i.divisor),
    .done_o     (div_done),
    .quotient_o (result_o)
  );

  assign status_o.busy     = v1_q | v2_q;
  assign status_o.div_done = div_done;

endmodule

// ===== hdl/sco_ctrl.sv =====
module sco_ctrl #(
  parameter int MAX_ASSETS  = sco_pkg::MAX_ASSETS_DEF,
  parameter int MAX_PERIODS = sco_pkg::MAX_PERIODS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_index_i,
  input  logic [sco_pkg::CFG_BITS-1:0]    cfg_data_i,
  input  logic                            in_valid_i,
  input  logic                            last_sample_i,
  output logic                            in_ready_o,
  output logic                            in_we_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [sco_pkg::ASSET_BITS-1:0]  row_index_o,
  output logic [sco_pkg::ASSET_BITS-1:0]  column_index_o,
  output logic                            last_entry_o,
  output sco_pkg::cmd_t                   cmd_o,
  output logic [$clog2(MAX_PERIODS)-1:0]  period_o,
  input  sco_pkg::status_t                status_i
);

  localparam int PW  = $clog2(MAX_PERIODS);
  localparam int NPB = sco_pkg::NP_BITS;
  localparam int NAB = sco_pkg::NA_BITS;
  localparam int XB  = sco_pkg::ASSET_BITS;
  localparam int KW  = (PW > NPB) ? PW : NPB;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_MSWEEP = 8'b0000_0010,
    ST_MDRAIN = 8'b0000_0100,
    ST_MDIV   = 8'b0000_1000,
    ST_CSWEEP = 8'b0001_0000,
    ST_CDRAIN = 8'b0010_0000,
    ST_CDIV   = 8'b0100_0000,
    ST_EMIT   = 8'b1000_0000
  } state_e;

  state_e          state_q, state_d;
  logic [NAB-1:0]  num_assets_q;
  logic [NPB-1:0]  num_periods_q;
  logic [XB-1:0]   row_q, row_d, col_q, col_d;
  logic [PW-1:0]   per_q, per_d;
  logic [NAB-1:0]  na;
  logic [NPB-1:0]  np;
  logic [XB-1:0]   na_m1;
  logic            per_last, row_last, col_last;

  // effective sizes, clamped to the supported range
  always_comb begin
    if (num_assets_q == '0) begin
      na = NAB'(1);
    end else if (32'(num_assets_q) > MAX_ASSETS) begin
      na = NAB'(MAX_ASSETS);
    end else begin
      na = num_assets_q;
    end
    if (num_periods_q < NPB'(2)) begin
      np = NPB'(2);
    end else if (32'(num_periods_q) > MAX_PERIODS) begin
      np = NPB'(MAX_PERIODS);
    end else begin
      np = num_periods_q;
    end
  end

  assign na_m1    = XB'(na - 1'b1);
  assign per_last = (KW'(per_q) == KW'(np) - KW'(1));
  assign row_last = (row_q == na_m1);
  assign col_last = (col_q == na_m1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_assets_q  <= NAB'(8);
      num_periods_q <= NPB'(256);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        sco_pkg::CFG_NUM_ASSETS:  num_assets_q  <= cfg_data_i[NAB-1:0];
        sco_pkg::CFG_NUM_PERIODS: num_periods_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    col_d   = col_q;
    per_d   = per_q;
    cmd_o   = '0;
    cmd_o.row = row_q;
    cmd_o.col = col_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && last_sample_i) begin
          state_d = ST_MSWEEP;
          row_d   = '0;
          col_d   = '0;
          per_d   = '0;
        end
      end
      ST_MSWEEP: begin
        cmd_o.issue = 1'b1;
        per_d = per_q + 1'b1;
        if (per_last) begin
          per_d   = '0;
          state_d = ST_MDRAIN;
        end
      end
      ST_MDRAIN: begin
        if (!status_i.busy) begin
          cmd_o.div_start = 1'b1;
          cmd_o.divisor   = np;
          state_d         = ST_MDIV;
        end
      end
      ST_MDIV: begin
        if (status_i.div_done) begin
          cmd_o.mean_we = 1'b1;
          if (row_last) begin
            row_d   = '0;
            state_d = ST_CSWEEP;
          end else begin
            row_d   = row_q + 1'b1;
            state_d = ST_MSWEEP;
          end
        end
      end
      ST_CSWEEP: begin
        cmd_o.issue    = 1'b1;
        cmd_o.cov_mode = 1'b1;
        per_d = per_q + 1'b1;
        if (per_last) begin
          per_d   = '0;
          state_d = ST_CDRAIN;
        end
      end
      ST_CDRAIN: begin
        if (!status_i.busy) begin
          cmd_o.div_start = 1'b1;
          cmd_o.divisor   = np - 1'b1;
          state_d         = ST_CDIV;
        end
      end
      ST_CDIV: begin
        if (status_i.div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_ready_i) begin
          state_d = ST_CSWEEP;
          if (col_last) begin
            col_d = '0;
            if (row_last) begin
              row_d   = '0;
              state_d = ST_IDLE;
            end else begin
              row_d = row_q + 1'b1;
            end
          end else begin
            col_d = col_q + 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      row_q   <= '0;
      col_q   <= '0;
      per_q   <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      per_q   <= per_d;
    end
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign in_we_o        = in_valid_i && in_ready_o;
  assign out_valid_o    = (state_q == ST_EMIT);
  assign row_index_o    = row_q;
  assign column_index_o = col_q;
  assign last_entry_o   = row_last && col_last;
  assign period_o       = per_q;

endmodule

// ===== hdl/sample_covariance_matrix_top.sv =====
// Sample covariance matrix. Each input item stores one Q1.15 return sample at
// (asset_index, period_index); samples persist across runs. An item with
// last_sample set stores its sample and then starts a run: per asset the mean
// over num_periods samples (truncated toward zero), then every entry of the
// num_assets x num_assets covariance matrix (Q.30, sum of deviation products
// divided by num_periods - 1, truncated toward zero), emitted row by row with
// last_entry on the final one. Input is refused while a run is in progress.
// A run is paced by the single multiply-accumulate path (one period per cycle
// on a two-port sample memory) and the shared bit-serial divider.
// Configuration must be written only while idle; the block itself does not
// enforce this.
module sample_covariance_matrix_top #(
  parameter int MAX_ASSETS  = sco_pkg::MAX_ASSETS_DEF,
  parameter int MAX_PERIODS = sco_pkg::MAX_PERIODS_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // configuration
  input  logic                                    cfg_we_i,
  input  logic                                    cfg_index_i,
  input  logic [sco_pkg::CFG_BITS-1:0]            cfg_data_i,
  // sample items
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic [sco_pkg::ASSET_BITS-1:0]          asset_index_i,
  input  logic [sco_pkg::PERIOD_BITS-1:0]         period_index_i,
  input  logic signed [sco_pkg::SAMPLE_BITS-1:0]  sample_value_i,
  input  logic                                    last_sample_i,
  // matrix entries
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic [sco_pkg::ASSET_BITS-1:0]          row_index_o,
  output logic [sco_pkg::ASSET_BITS-1:0]          column_index_o,
  output logic signed [sco_pkg::ACC_BITS-1:0]     covariance_value_o,
  output logic                                    last_entry_o
);

  sco_pkg::cmd_t                cmd;
  sco_pkg::status_t             status;
  logic [$clog2(MAX_PERIODS)-1:0] period;
  logic                         in_we;

  // sequencer: sweeps, drain waits, divides, emission
  sco_ctrl #(
    .MAX_ASSETS  (MAX_ASSETS),
    .MAX_PERIODS (MAX_PERIODS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .last_sample_i  (last_sample_i),
    .in_ready_o     (in_ready_o),
    .in_we_o        (in_we),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .row_index_o    (row_index_o),
    .column_index_o (column_index_o),
    .last_entry_o   (last_entry_o),
    .cmd_o          (cmd),
    .period_o       (period),
    .status_i       (status)
  );

  // sample store, means, MAC pipeline and divider
  sco_datapath #(
    .MAX_ASSETS  (MAX_ASSETS),
    .MAX_PERIODS (MAX_PERIODS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_we_i        (in_we),
    .asset_index_i  (asset_index_i),
    .period_index_i (period_index_i),
    .sample_value_i (sample_value_i),
    .cmd_i          (cmd),
    .period_i       (period),
    .status_o       (status),
    .result_o       (covariance_value_o)
  );

endmodule

// ===== dv/sample_covariance_matrix_top_tb.sv =====
module sample_covariance_matrix_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int XB  = sco_pkg::ASSET_BITS;
  localparam int PB  = sco_pkg::PERIOD_BITS;
  localparam int SB  = sco_pkg::SAMPLE_BITS;
  localparam int AB  = sco_pkg::ACC_BITS;
  localparam int CB  = sco_pkg::CFG_BITS;
  localparam int NAB = sco_pkg::NA_BITS;
  localparam int NPB = sco_pkg::NP_BITS;
  localparam int MA  = sco_pkg::MAX_ASSETS_DEF;
  localparam int MP  = sco_pkg::MAX_PERIODS_DEF;

  // window that is filled first; every run reads only inside it
  localparam int FILL_ASSETS  = 8;
  localparam int FILL_PERIODS = 4;
  localparam int RANDOM_ITEMS = 62;

  // One matrix entry as the block should emit it
  typedef struct {
    logic [XB-1:0]        row;
    logic [XB-1:0]        col;
    logic signed [AB-1:0] cov;
    logic                 last;
  } cov_entry_t;

  localparam longint ACC_HI = (64'sd1 <<< (AB - 1)) - 1;
  localparam longint ACC_LO = -ACC_HI - 1;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic                 cfg_index_i = sco_pkg::CFG_NUM_ASSETS;
  logic [CB-1:0]        cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [XB-1:0]        asset_index_i = '0;
  logic [PB-1:0]        period_index_i = '0;
  logic signed [SB-1:0] sample_value_i = '0;
  logic                 last_sample_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [XB-1:0]        row_index_o;
  logic [XB-1:0]        column_index_o;
  logic signed [AB-1:0] covariance_value_o;
  logic                 last_entry_o;

  sample_covariance_matrix_top uut (.*);

  always #2 clk_i = ~clk_i;

  // Shadow of the block: sample store and the two registers
  logic signed [SB-1:0] sample_shadow [MA][MP];
  logic [NAB-1:0]       assets_reg = 4'd8;
  logic [NPB-1:0]       periods_reg = 9'd256;

  cov_entry_t expected_entries[$];
  int         error_count = 0;
  bit         no_idle = 1'b0;   // set for stretches without gaps on either side

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    error_count++;
  endtask

  // Means per asset, then every covariance entry in row order
  function automatic void predict_matrix();
    int     na, np;
    longint mean [MA];
    longint sum, acc;
    cov_entry_t e;
    na = (assets_reg == 0) ? 1 : ((assets_reg > MA) ? MA : assets_reg);
    np = (periods_reg < 2) ? 2 : ((periods_reg > MP) ? MP : periods_reg);
    for (int i = 0; i < na; i++) begin
      sum = 0;
      for (int k = 0; k < np; k++) sum += longint'(sample_shadow[i][k]);
      mean[i] = sum / np;
    end
    for (int i = 0; i < na; i++) begin
      for (int j = 0; j < na; j++) begin
        acc = 0;
        for (int k = 0; k < np; k++) begin
          acc += (longint'(sample_shadow[i][k]) - mean[i]) *
                 (longint'(sample_shadow[j][k]) - mean[j]);
          if (acc > ACC_HI) acc = ACC_HI;
          if (acc < ACC_LO) acc = ACC_LO;
        end
        e.row  = i[XB-1:0];
        e.col  = j[XB-1:0];
        e.cov  = AB'(acc / (np - 1));
        e.last = (i == na - 1) && (j == na - 1);
        expected_entries.push_back(e);
      end
    end
  endfunction

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 9);
  endfunction

  // Send one sample item; valid stays high afterwards unless a gap follows
  task automatic send_sample(input logic [XB-1:0] asset,
                             input logic [PB-1:0] period,
                             input logic signed [SB-1:0] value,
                             input logic last);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    asset_index_i  <= asset;
    period_index_i <= period;
    sample_value_i <= value;
    last_sample_i  <= last;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    sample_shadow[asset][period] = value;
    if (last) predict_matrix();
  endtask

  // Drop valid and let every outstanding entry drain before touching registers
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_entries.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [CB-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == sco_pkg::CFG_NUM_ASSETS) assets_reg = data[NAB-1:0];
    else periods_reg = data[NPB-1:0];
    @(posedge clk_i);
  endtask

  // Result side: random stall per entry, then compare against the oldest expectation
  initial begin
    cov_entry_t e;
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
      if (expected_entries.size() == 0) begin
        report_mismatch($sformatf("unexpected entry (%0d,%0d)", row_index_o, column_index_o));
      end else begin
        e = expected_entries.pop_front();
        if (row_index_o !== e.row)
          report_mismatch($sformatf("row %0d, want %0d", row_index_o, e.row));
        if (column_index_o !== e.col)
          report_mismatch($sformatf("column %0d, want %0d", column_index_o, e.col));
        if (covariance_value_o !== e.cov)
          report_mismatch($sformatf("cov (%0d,%0d) %0d, want %0d",
                                    e.row, e.col, covariance_value_o, e.cov));
        if (last_entry_o !== e.last)
          report_mismatch($sformatf("last_entry %0b, want %0b", last_entry_o, e.last));
      end
    end
  end

  // Fill the window at all eight assets; every later run reads only written
  // entries. Extremes sit in the first two periods.
  task automatic test_fill_window();
    logic signed [SB-1:0] v;
    write_reg(sco_pkg::CFG_NUM_ASSETS, CB'(FILL_ASSETS));
    write_reg(sco_pkg::CFG_NUM_PERIODS, CB'(FILL_PERIODS));
    for (int a = 0; a < FILL_ASSETS; a++) begin
      for (int p = 0; p < FILL_PERIODS; p++) begin
        if (p == 0) v = 16'sh8000;
        else if (p == 1) v = 16'sh7fff;
        else v = SB'($urandom());
        send_sample(XB'(a), PB'(p), v,
                    (a == FILL_ASSETS - 1) && (p == FILL_PERIODS - 1));
      end
    end
    wait_idle();
  endtask

  // Smallest matrix, extreme deviations, and a constant asset (zero variance)
  task automatic test_directed_small();
    write_reg(sco_pkg::CFG_NUM_ASSETS, 9'd1);
    write_reg(sco_pkg::CFG_NUM_PERIODS, 9'd2);
    send_sample(3'd0, 8'd0, 16'sh8000, 1'b0);
    send_sample(3'd0, 8'd1, 16'sh7fff, 1'b1);
    wait_idle();
    write_reg(sco_pkg::CFG_NUM_ASSETS, 9'd3);
    write_reg(sco_pkg::CFG_NUM_PERIODS, 9'd3);
    no_idle = 1'b1;
    for (int p = 0; p < 3; p++) begin
      send_sample(3'd0, PB'(p), 16'sh8000, 1'b0);
      send_sample(3'd1, PB'(p), (p == 1) ? 16'sh7fff : 16'sh8000, 1'b0);
      send_sample(3'd2, PB'(p), 16'sh1234, 1'b0);
    end
    no_idle = 1'b0;
    send_sample(3'd1, 8'd2, -16'sd7, 1'b1);   // own sample stored before the run
    wait_idle();
    // last item addressed outside the active window still starts a run
    send_sample(3'd7, 8'd255, 16'sh0001, 1'b1);
    wait_idle();
  endtask

  // Out-of-range register values are clamped
  task automatic test_register_clamp();
    write_reg(sco_pkg::CFG_NUM_ASSETS, 9'd0);
    write_reg(sco_pkg::CFG_NUM_PERIODS, 9'd1);
    send_sample(3'd0, 8'd1, 16'sh4000, 1'b1);
    wait_idle();
    write_reg(sco_pkg::CFG_NUM_ASSETS, 9'd2);
    write_reg(sco_pkg::CFG_NUM_PERIODS, 9'd0);
    send_sample(3'd1, 8'd0, -16'sd100, 1'b1);
    wait_idle();
    write_reg(sco_pkg::CFG_NUM_ASSETS, 9'd15);
    write_reg(sco_pkg::CFG_NUM_PERIODS, 9'd3);
    send_sample(3'd3, 8'd2, 16'sh7ffe, 1'b1);
    wait_idle();
  endtask

  // Random phases inside the filled window, some stray writes anywhere;
  // last on roughly every eighth in-window item and at the end of each phase
  task automatic test_random();
    int na, np, sent;
    logic signed [SB-1:0] v;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      na = $urandom_range(1, FILL_ASSETS);
      np = $urandom_range(2, FILL_PERIODS);
      write_reg(sco_pkg::CFG_NUM_ASSETS, CB'(na));
      write_reg(sco_pkg::CFG_NUM_PERIODS, CB'(np));
      no_idle = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < 16 && sent < RANDOM_ITEMS; n++) begin
        case ($urandom_range(0, 5))
          0:       v = 16'sh8000;
          1:       v = 16'sh7fff;
          default: v = SB'($urandom());
        endcase
        if ($urandom_range(0, 4) == 0)
          send_sample(XB'($urandom_range(0, 7)), PB'($urandom_range(0, 255)), v, 1'b0);
        else
          send_sample(XB'($urandom_range(0, na - 1)), PB'($urandom_range(0, np - 1)), v,
                      $urandom_range(0, 7) == 0);
        sent++;
      end
      send_sample(XB'($urandom_range(0, na - 1)), PB'($urandom_range(0, np - 1)),
                  SB'($urandom()), 1'b1);
      sent++;
      wait_idle();
      no_idle = 1'b0;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_fill_window();
    test_directed_small();
    test_register_clamp();
    test_random();
    wait_idle();
    repeat (100) @(posedge clk_i);
    if (error_count == 0 && expected_entries.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Overall guard against a hung handshake
  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/sco_pkg.sv
hdl/sco_div.sv
hdl/sco_datapath.sv
hdl/sco_ctrl.sv
hdl/sample_covariance_matrix_top.sv
dv/sample_covariance_matrix_top_tb.sv
